// ===== rtl/ppd_pkg.sv =====
// Shared types, constants and codes of the point to polyline distance unit.
`default_nettype none
package ppd_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_POINTS);

   localparam int POINT_W    = 64;
   localparam int N_W        = 132;
   localparam int DEN_W      = 66;
   localparam int Q_W        = 68;
   localparam int ROOT_W     = 34;
   localparam int DIV_STEPS  = Q_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W     = 7;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FEW    = 2'd1;
   localparam logic [1:0] STATUS_REPEAT = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } ppd_req_type;

   typedef struct packed {
      logic [31:0] distance;
      logic [1:0]  status;
      logic        overflow;
   } ppd_rsp_type;

   typedef struct packed {
      logic             start;
      logic             use_div;
      logic [N_W-1:0]   num;
      logic [DEN_W-1:0] den;
   } ppd_root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } ppd_root_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FIRST, ST_FIRST_WAIT, ST_FETCH, ST_LOAD,
      ST_NUM_A, ST_NUM_B, ST_DEN_A, ST_DEN_B, ST_DECIDE,
      ST_SQ_A, ST_SQ_B, ST_SQ_END,
      ST_CR_A, ST_CR_B, ST_CR_END,
      ST_CS_A, ST_CS_B, ST_CS_C, ST_CS_END,
      ST_ROOT, ST_ROOT_WAIT, ST_FINISH
   } ppd_state_type;

   typedef enum logic [1:0] {
      R_IDLE, R_DIV, R_SQRT
   } ppd_root_state_type;

endpackage
`default_nettype wire

// ===== rtl/ppd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ppd_root.sv =====
// Bit-serial divide (when use_div is set) followed by bit-serial integer square root.
`default_nettype none
module ppd_root (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ppd_pkg::ppd_root_req_type root_req,
   output ppd_pkg::ppd_root_rsp_type     root_rsp
);

   ppd_pkg::ppd_root_state_type state_ff, state_in;

   logic [ppd_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [ppd_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [ppd_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [ppd_pkg::Q_W-1:0]     q_ff, q_in;
   logic [ppd_pkg::ROOT_W:0]    srem_ff, srem_in;
   logic [ppd_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic                        done_ff, done_in;

   logic [ppd_pkg::DEN_W:0]     div_t;
   logic                        div_ge;
   logic [ppd_pkg::ROOT_W+2:0]  sq_t;
   logic [ppd_pkg::ROOT_W+2:0]  sq_trial;
   logic                        sq_ge;
   logic                        div_last;
   logic                        sq_last;

   assign div_t    = {rem_ff, q_ff[ppd_pkg::Q_W-1]};
   assign div_ge   = div_t >= {1'b0, den_ff};
   assign sq_t     = {srem_ff, q_ff[ppd_pkg::Q_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;
   assign div_last = cnt_ff == ppd_pkg::STEP_W'(ppd_pkg::DIV_STEPS - 1);
   assign sq_last  = cnt_ff == ppd_pkg::STEP_W'(ppd_pkg::ROOT_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppd_pkg::R_IDLE: begin
            if (root_req.start) begin
               state_in = root_req.use_div ? ppd_pkg::R_DIV : ppd_pkg::R_SQRT;
            end
         end
         ppd_pkg::R_DIV: begin
            if (div_last) begin
               state_in = ppd_pkg::R_SQRT;
            end
         end
         ppd_pkg::R_SQRT: begin
            if (sq_last) begin
               state_in = ppd_pkg::R_IDLE;
            end
         end
         default: state_in = ppd_pkg::R_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      done_in = 1'b0;
      unique case (state_ff)
         ppd_pkg::R_IDLE: begin
            if (root_req.start) begin
               cnt_in  = '0;
               rem_in  = {2'b00, root_req.num[ppd_pkg::N_W-1:ppd_pkg::Q_W]};
               den_in  = root_req.den;
               q_in    = root_req.num[ppd_pkg::Q_W-1:0];
               srem_in = '0;
               root_in = '0;
            end
         end
         ppd_pkg::R_DIV: begin
            rem_in = div_ge ? ppd_pkg::DEN_W'(div_t - {1'b0, den_ff})
                            : div_t[ppd_pkg::DEN_W-1:0];
            q_in   = {q_ff[ppd_pkg::Q_W-2:0], div_ge};
            cnt_in = div_last ? '0 : cnt_ff + ppd_pkg::STEP_W'(1);
         end
         ppd_pkg::R_SQRT: begin
            srem_in = sq_ge ? (ppd_pkg::ROOT_W+1)'(sq_t - sq_trial)
                            : sq_t[ppd_pkg::ROOT_W:0];
            root_in = {root_ff[ppd_pkg::ROOT_W-2:0], sq_ge};
            q_in    = {q_ff[ppd_pkg::Q_W-3:0], 2'b00};
            cnt_in  = cnt_ff + ppd_pkg::STEP_W'(1);
            done_in = sq_last;
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppd_pkg::R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign root_rsp.done = done_ff;
   assign root_rsp.root = root_ff;

endmodule
`default_nettype wire

// ===== rtl/point_to_polyline_distance_unit.sv =====
// Top level of the point to polyline distance unit.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | ppd_req_type: kind, x, y
//   rsp     | out | rsp_valid/stall    | ppd_rsp_type: distance, status, overflow
//
// Clear and append are handled in the idle state and do not stall req. A query
// on fewer than two points, or one that meets a repeated point, goes straight
// to the finish state. A query walks its segments one at a time: an endpoint
// segment needs only the square root; a perpendicular one the bit-serial
// divide (68 steps) and then the square root (34 steps) in ppd_root, with the
// products formed one after another on a single multiplier.
// Synchronous reset empties the path and clears the overflow flag.
// req is stalled while a query runs; a finished request waits in the output
// register and the next request is taken while it waits.
`default_nettype none
module point_to_polyline_distance_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ppd_pkg::ppd_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ppd_pkg::ppd_rsp_type      rsp_data
);

   ppd_pkg::ppd_state_type state_ff, state_in;

   logic [ppd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        overflow_ff, overflow_in;
   logic signed [31:0]          px_ff, px_in, py_ff, py_in;
   logic [ppd_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic [ppd_pkg::POINT_W-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic signed [32:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic signed [32:0]          ex_ff, ex_in, ey_ff, ey_in;
   logic signed [32:0]          fx_ff, fx_in, fy_ff, fy_in;
   logic signed [67:0]          prod_ff, prod_in;
   logic signed [68:0]          num_ff, num_in, den_ff, den_in, cr_ff, cr_in;
   logic [ppd_pkg::N_W-1:0]     n_ff, n_in;
   logic                        sel_f_ff, sel_f_in;
   logic                        div_ff, div_in;
   logic [ppd_pkg::ROOT_W-1:0]  best_ff, best_in;
   logic                        have_ff, have_in;
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ppd_pkg::ppd_rsp_type        rsp_ff, rsp_in;

   logic                        wr_en;
   logic [ppd_pkg::ADDR_W-1:0]  wr_addr;
   logic                        rd_en;
   logic [ppd_pkg::ADDR_W-1:0]  rd_addr;
   logic [ppd_pkg::POINT_W-1:0] rd_data;

   ppd_pkg::ppd_root_req_type   root_req;
   ppd_pkg::ppd_root_rsp_type   root_rsp;

   logic                        accept;
   logic signed [33:0]          mul_a, mul_b;
   logic signed [68:0]          prod_x;
   logic signed [68:0]          den_sum;
   logic [65:0]                 cr_abs;
   logic [32:0]                 cr_hi, cr_lo;
   logic                        num_le_zero, den_le_num;
   logic                        pts_equal, last_seg, slot_free, better;
   logic [ppd_pkg::COUNT_W-1:0] idx_next;
   logic signed [32:0]          sq_u, sq_v;

   ppd_ram #(
      .WIDTH(ppd_pkg::POINT_W),
      .DEPTH(ppd_pkg::MAX_POINTS)
   ) u_points (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({req_data.y, req_data.x}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ppd_root u_root (
      .clock   (clock),
      .reset   (reset),
      .root_req(root_req),
      .root_rsp(root_rsp)
   );

   assign req_stall   = state_ff != ppd_pkg::ST_IDLE;
   assign accept      = req_valid && !req_stall;
   assign prod_x      = {prod_ff[67], prod_ff};
   assign den_sum     = den_ff + prod_x;
   assign cr_abs      = cr_ff[68] ? 66'(-cr_ff) : cr_ff[65:0];
   assign cr_hi       = cr_abs[65:33];
   assign cr_lo       = cr_abs[32:0];
   assign num_le_zero = num_ff[68] || (num_ff == '0);
   assign den_le_num  = den_sum <= num_ff;
   assign pts_equal   = rd_data == prev_ff;
   assign idx_next    = idx_ff + ppd_pkg::COUNT_W'(1);
   assign last_seg    = idx_next >= count_ff;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign better      = !have_ff || (root_rsp.root < best_ff);
   assign sq_u        = sel_f_ff ? fx_ff : ex_ff;
   assign sq_v        = sel_f_ff ? fy_ff : ey_ff;
   assign prod_in     = mul_a * mul_b;

   assign root_req.start   = state_ff == ppd_pkg::ST_ROOT;
   assign root_req.use_div = div_ff;
   assign root_req.num     = n_ff;
   assign root_req.den     = den_ff[ppd_pkg::DEN_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppd_pkg::ST_IDLE: begin
            if (accept && req_data.kind == ppd_pkg::KIND_QUERY) begin
               state_in = (count_ff < ppd_pkg::COUNT_W'(2)) ? ppd_pkg::ST_FINISH
                                                           : ppd_pkg::ST_FIRST;
            end
         end
         ppd_pkg::ST_FIRST:      state_in = ppd_pkg::ST_FIRST_WAIT;
         ppd_pkg::ST_FIRST_WAIT: state_in = ppd_pkg::ST_FETCH;
         ppd_pkg::ST_FETCH:      state_in = ppd_pkg::ST_LOAD;
         ppd_pkg::ST_LOAD:       state_in = pts_equal ? ppd_pkg::ST_FINISH : ppd_pkg::ST_NUM_A;
         ppd_pkg::ST_NUM_A:      state_in = ppd_pkg::ST_NUM_B;
         ppd_pkg::ST_NUM_B:      state_in = ppd_pkg::ST_DEN_A;
         ppd_pkg::ST_DEN_A:      state_in = ppd_pkg::ST_DEN_B;
         ppd_pkg::ST_DEN_B:      state_in = ppd_pkg::ST_DECIDE;
         ppd_pkg::ST_DECIDE: begin
            state_in = (num_le_zero || den_le_num) ? ppd_pkg::ST_SQ_A : ppd_pkg::ST_CR_A;
         end
         ppd_pkg::ST_SQ_A:       state_in = ppd_pkg::ST_SQ_B;
         ppd_pkg::ST_SQ_B:       state_in = ppd_pkg::ST_SQ_END;
         ppd_pkg::ST_SQ_END:     state_in = ppd_pkg::ST_ROOT;
         ppd_pkg::ST_CR_A:       state_in = ppd_pkg::ST_CR_B;
         ppd_pkg::ST_CR_B:       state_in = ppd_pkg::ST_CR_END;
         ppd_pkg::ST_CR_END:     state_in = ppd_pkg::ST_CS_A;
         ppd_pkg::ST_CS_A:       state_in = ppd_pkg::ST_CS_B;
         ppd_pkg::ST_CS_B:       state_in = ppd_pkg::ST_CS_C;
         ppd_pkg::ST_CS_C:       state_in = ppd_pkg::ST_CS_END;
         ppd_pkg::ST_CS_END:     state_in = ppd_pkg::ST_ROOT;
         ppd_pkg::ST_ROOT:       state_in = ppd_pkg::ST_ROOT_WAIT;
         ppd_pkg::ST_ROOT_WAIT: begin
            if (root_rsp.done) begin
               state_in = last_seg ? ppd_pkg::ST_FINISH : ppd_pkg::ST_FETCH;
            end
         end
         ppd_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = ppd_pkg::ST_IDLE;
            end
         end
         default: state_in = ppd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      cr_in        = cr_ff;
      n_in         = n_ff;
      sel_f_in     = sel_f_ff;
      div_in       = div_ff;
      best_in      = best_ff;
      have_in      = have_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ppd_pkg::ADDR_W-1:0];
      rd_en        = 1'b0;
      rd_addr      = idx_ff[ppd_pkg::ADDR_W-1:0];
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ppd_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  ppd_pkg::KIND_CLEAR: count_in = '0;
                  ppd_pkg::KIND_APPEND: begin
                     if (count_ff < ppd_pkg::MAX_COUNT) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + ppd_pkg::COUNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  ppd_pkg::KIND_QUERY: begin
                     px_in     = req_data.x;
                     py_in     = req_data.y;
                     best_in   = '0;
                     have_in   = 1'b0;
                     status_in = (count_ff < ppd_pkg::COUNT_W'(2)) ? ppd_pkg::STATUS_FEW
                                                                  : ppd_pkg::STATUS_OK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ppd_pkg::ST_FIRST: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_in  = ppd_pkg::COUNT_W'(1);
         end
         ppd_pkg::ST_FIRST_WAIT: prev_in = rd_data;
         ppd_pkg::ST_FETCH:      rd_en   = 1'b1;
         ppd_pkg::ST_LOAD: begin
            if (pts_equal) begin
               status_in = ppd_pkg::STATUS_REPEAT;
               best_in   = '0;
            end else begin
               cur_in = rd_data;
               dx_in  = {rd_data[31], rd_data[31:0]} - {prev_ff[31], prev_ff[31:0]};
               dy_in  = {rd_data[63], rd_data[63:32]} - {prev_ff[63], prev_ff[63:32]};
               ex_in  = {px_ff[31], px_ff} - {prev_ff[31], prev_ff[31:0]};
               ey_in  = {py_ff[31], py_ff} - {prev_ff[63], prev_ff[63:32]};
               fx_in  = {px_ff[31], px_ff} - {rd_data[31], rd_data[31:0]};
               fy_in  = {py_ff[31], py_ff} - {rd_data[63], rd_data[63:32]};
            end
         end
         ppd_pkg::ST_NUM_A: begin
            mul_a = {dx_ff[32], dx_ff};
            mul_b = {ex_ff[32], ex_ff};
         end
         ppd_pkg::ST_NUM_B: begin
            mul_a  = {dy_ff[32], dy_ff};
            mul_b  = {ey_ff[32], ey_ff};
            num_in = prod_x;
         end
         ppd_pkg::ST_DEN_A: begin
            mul_a  = {dx_ff[32], dx_ff};
            mul_b  = {dx_ff[32], dx_ff};
            num_in = num_ff + prod_x;
         end
         ppd_pkg::ST_DEN_B: begin
            mul_a  = {dy_ff[32], dy_ff};
            mul_b  = {dy_ff[32], dy_ff};
            den_in = prod_x;
         end
         ppd_pkg::ST_DECIDE: begin
            den_in   = den_sum;
            sel_f_in = !num_le_zero;
            div_in   = !(num_le_zero || den_le_num);
         end
         ppd_pkg::ST_SQ_A: begin
            mul_a = {sq_u[32], sq_u};
            mul_b = {sq_u[32], sq_u};
         end
         ppd_pkg::ST_SQ_B: begin
            mul_a = {sq_v[32], sq_v};
            mul_b = {sq_v[32], sq_v};
            n_in  = {64'd0, prod_ff};
         end
         ppd_pkg::ST_SQ_END: n_in = n_ff + {64'd0, prod_ff};
         ppd_pkg::ST_CR_A: begin
            mul_a = {dx_ff[32], dx_ff};
            mul_b = {ey_ff[32], ey_ff};
         end
         ppd_pkg::ST_CR_B: begin
            mul_a = {dy_ff[32], dy_ff};
            mul_b = {ex_ff[32], ex_ff};
            cr_in = prod_x;
         end
         ppd_pkg::ST_CR_END: cr_in = cr_ff - prod_x;
         ppd_pkg::ST_CS_A: begin
            mul_a = {1'b0, cr_hi};
            mul_b = {1'b0, cr_hi};
         end
         ppd_pkg::ST_CS_B: begin
            mul_a = {1'b0, cr_hi};
            mul_b = {1'b0, cr_lo};
            n_in  = {prod_ff[65:0], 66'd0};
         end
         ppd_pkg::ST_CS_C: begin
            mul_a = {1'b0, cr_lo};
            mul_b = {1'b0, cr_lo};
            n_in  = n_ff + {30'd0, prod_ff, 34'd0};
         end
         ppd_pkg::ST_CS_END: n_in = n_ff + {64'd0, prod_ff};
         ppd_pkg::ST_ROOT: begin
         end
         ppd_pkg::ST_ROOT_WAIT: begin
            if (root_rsp.done) begin
               if (better) begin
                  best_in = root_rsp.root;
                  have_in = 1'b1;
               end
               prev_in = cur_ff;
               idx_in  = idx_next;
            end
         end
         ppd_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.distance = (best_ff[ppd_pkg::ROOT_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                      : best_ff[31:0];
               rsp_in.status   = status_ff;
               rsp_in.overflow = overflow_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppd_pkg::ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff     <= px_in;
      py_ff     <= py_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      fx_ff     <= fx_in;
      fy_ff     <= fy_in;
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      cr_ff     <= cr_in;
      n_ff      <= n_in;
      sel_f_ff  <= sel_f_in;
      div_ff    <= div_in;
      best_ff   <= best_in;
      have_ff   <= have_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ppd_pkg::MAX_COUNT)
      else $error("point count beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == ppd_pkg::KIND_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the path");

   a_repeat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ppd_pkg::STATUS_REPEAT) |-> rsp_ff.distance == '0)
      else $error("repeated point result with nonzero distance");

   a_root_done_wait: assert property (@(posedge clock) disable iff (reset)
      root_rsp.done |-> state_ff == ppd_pkg::ST_ROOT_WAIT)
      else $error("root unit finished outside a segment walk");

endmodule
`default_nettype wire
